@@ rtl/gcrl_pkg.sv @@
`timescale 1ns / 1ps

package gcrl_pkg;

  localparam int unsigned PosW   = 16;
  localparam int unsigned ColorW = 64;
  localparam int unsigned ChanW  = 16;
  localparam int unsigned NumCh  = 4;
  localparam int unsigned CountW = 5;
  localparam int unsigned QuoW   = 17;
  localparam int unsigned ProdW  = ChanW + QuoW;

  // power-up contents of the stop table
  localparam logic [PosW-1:0]   PosEntry1   = 16'hFFFF;
  localparam logic [ColorW-1:0] ColorEntry0 = 64'hFFFF_0000_0000_0000;
  localparam logic [ColorW-1:0] ColorEntry1 = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam logic [CountW-1:0] CountReset  = 5'd2;

  typedef enum logic {
    OP_WRITE  = 1'b0,
    OP_LOOKUP = 1'b1
  } op_e;

  typedef enum logic [2:0] {
    RD_NONE,
    RD_FIRST,
    RD_LAST,
    RD_SEG,
    RD_NEXT
  } rd_sel_e;

  typedef enum logic [2:0] {
    RES_NONE,
    RES_RD,
    RES_LO,
    RES_ZERO,
    RES_MIX
  } res_sel_e;

  typedef struct packed {
    logic     wr_stop;
    logic     p_load;
    rd_sel_e  rd_sel;
    logic     lo_load;
    logic     div_start;
    logic     div_step;
    logic     mul_load;
    res_sel_e res_sel;
    logic     out_load;
  } cmd_t;

  typedef struct packed {
    logic lt_first;
    logic gt_last;
    logic in_seg;
    logic zero_w;
    logic last_seg;
    logic div_last;
  } status_t;

endpackage

@@ rtl/gcrl_datapath.sv @@
`timescale 1ns / 1ps

module gcrl_datapath #(
  parameter int unsigned MAX_STOPS = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  gcrl_pkg::cmd_t                 cmd_i,
  output gcrl_pkg::status_t              status_o,
  input  logic                           stop_count_we_i,
  input  logic [gcrl_pkg::CountW-1:0]    stop_count_i,
  input  logic [3:0]                     stop_index_i,
  input  logic [gcrl_pkg::PosW-1:0]      stop_position_i,
  input  logic [gcrl_pkg::ChanW-1:0]     stop_alpha_i,
  input  logic [gcrl_pkg::ChanW-1:0]     stop_red_i,
  input  logic [gcrl_pkg::ChanW-1:0]     stop_green_i,
  input  logic [gcrl_pkg::ChanW-1:0]     stop_blue_i,
  input  logic [gcrl_pkg::PosW-1:0]      lookup_position_i,
  output logic [gcrl_pkg::ChanW-1:0]     out_alpha_o,
  output logic [gcrl_pkg::ChanW-1:0]     out_red_o,
  output logic [gcrl_pkg::ChanW-1:0]     out_green_o,
  output logic [gcrl_pkg::ChanW-1:0]     out_blue_o
);

  localparam int unsigned AW = (MAX_STOPS > 2) ? $clog2(MAX_STOPS) : 1;
  localparam logic [AW-1:0] LastMax = AW'(MAX_STOPS - 1);
  localparam logic [AW-1:0] AddrOne = AW'(1);

  // stop table storage
  logic [gcrl_pkg::PosW-1:0]   pos_mem [MAX_STOPS];
  logic [gcrl_pkg::ColorW-1:0] col_mem [MAX_STOPS];
  logic [MAX_STOPS-1:0]        vld_q;

  logic [gcrl_pkg::CountW-1:0] stop_count_q;
  logic [AW-1:0]               last_idx;
  logic [AW-1:0]               wr_addr;
  logic                        wr_ok;

  logic [AW-1:0]               rd_addr;
  logic [AW-1:0]               raddr_q;
  logic                        rvld_q;
  logic [gcrl_pkg::PosW-1:0]   rpos_q;
  logic [gcrl_pkg::ColorW-1:0] rcol_q;
  logic [gcrl_pkg::PosW-1:0]   rd_pos;
  logic [gcrl_pkg::ColorW-1:0] rd_col;

  logic [AW-1:0]               idx_q;
  logic [gcrl_pkg::PosW-1:0]   p_q;
  logic [gcrl_pkg::PosW-1:0]   lo_pos_q;
  logic [gcrl_pkg::ColorW-1:0] lo_col_q;
  logic [gcrl_pkg::ColorW-1:0] hi_col_q;

  logic [gcrl_pkg::PosW-1:0]   div_d;
  logic [gcrl_pkg::PosW-1:0]   div_w;
  logic                        div_ge0;
  logic [gcrl_pkg::PosW-1:0]   rem_q;
  logic [gcrl_pkg::PosW-1:0]   w_q;
  logic [gcrl_pkg::QuoW-1:0]   quo_q;
  logic [3:0]                  cnt_q;
  logic [gcrl_pkg::PosW:0]     rem_sh;
  logic [gcrl_pkg::PosW:0]     rem_sub;
  logic                        step_ge;

  logic [gcrl_pkg::ProdW-1:0]  prod_q [gcrl_pkg::NumCh];
  logic [gcrl_pkg::ProdW-1:0]  prod_d [gcrl_pkg::NumCh];
  logic [gcrl_pkg::ColorW-1:0] mix_col;
  logic [gcrl_pkg::ColorW-1:0] res_q;
  logic [gcrl_pkg::ColorW-1:0] out_q;

  // effective last stop index, count clamped to the table
  always_comb begin
    if (stop_count_q < 5'd2) begin
      last_idx = AddrOne;
    end else if (32'(stop_count_q) > MAX_STOPS) begin
      last_idx = LastMax;
    end else begin
      last_idx = AW'(stop_count_q - 5'd1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stop_count_q <= gcrl_pkg::CountReset;
    end else if (stop_count_we_i) begin
      stop_count_q <= stop_count_i;
    end
  end

  // stop writes, out-of-range indexes dropped
  assign wr_addr = AW'(stop_index_i);
  assign wr_ok   = (32'(stop_index_i) < MAX_STOPS);

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_stop && wr_ok) begin
      pos_mem[wr_addr] <= stop_position_i;
      col_mem[wr_addr] <= {stop_alpha_i, stop_red_i, stop_green_i, stop_blue_i};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (cmd_i.wr_stop && wr_ok) begin
      vld_q[wr_addr] <= 1'b1;
    end
  end

  // read address select
  always_comb begin
    case (cmd_i.rd_sel)
      gcrl_pkg::RD_FIRST: rd_addr = '0;
      gcrl_pkg::RD_LAST:  rd_addr = last_idx;
      gcrl_pkg::RD_SEG:   rd_addr = AddrOne;
      gcrl_pkg::RD_NEXT:  rd_addr = idx_q + AddrOne;
      default:            rd_addr = idx_q;
    endcase
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_sel != gcrl_pkg::RD_NONE) begin
      rpos_q  <= pos_mem[rd_addr];
      rcol_q  <= col_mem[rd_addr];
      rvld_q  <= vld_q[rd_addr];
      raddr_q <= rd_addr;
    end
  end

  // never-written entries read back their power-up value
  always_comb begin
    if (rvld_q) begin
      rd_pos = rpos_q;
      rd_col = rcol_q;
    end else if (raddr_q == '0) begin
      rd_pos = '0;
      rd_col = gcrl_pkg::ColorEntry0;
    end else if (raddr_q == AddrOne) begin
      rd_pos = gcrl_pkg::PosEntry1;
      rd_col = gcrl_pkg::ColorEntry1;
    end else begin
      rd_pos = '0;
      rd_col = '0;
    end
  end

  // scan index and segment bounds
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
    end else if (cmd_i.rd_sel == gcrl_pkg::RD_SEG || cmd_i.rd_sel == gcrl_pkg::RD_NEXT) begin
      idx_q <= rd_addr;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.p_load) begin
      p_q <= lookup_position_i;
    end
    if (cmd_i.lo_load) begin
      lo_pos_q <= rd_pos;
      lo_col_q <= rd_col;
    end
    if (cmd_i.div_start) begin
      hi_col_q <= rd_col;
    end
  end

  assign status_o.lt_first = (p_q < rd_pos);
  assign status_o.gt_last  = (p_q > rd_pos);
  assign status_o.in_seg   = (p_q >= lo_pos_q) && (p_q <= rd_pos);
  assign status_o.zero_w   = (rd_pos == lo_pos_q);
  assign status_o.last_seg = (idx_q == last_idx);
  assign status_o.div_last = (cnt_q == '0);

  // restoring divider, fraction = (d << 16) / w, one quotient bit per cycle
  assign div_d   = p_q - lo_pos_q;
  assign div_w   = rd_pos - lo_pos_q;
  assign div_ge0 = (div_d >= div_w);
  assign rem_sh  = {rem_q, 1'b0};
  assign rem_sub = rem_sh - {1'b0, w_q};
  assign step_ge = (rem_sh >= {1'b0, w_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (cmd_i.div_start) begin
      cnt_q <= 4'd15;
    end else if (cmd_i.div_step) begin
      cnt_q <= cnt_q - 4'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_start) begin
      rem_q <= div_ge0 ? (div_d - div_w) : div_d;
      w_q   <= div_w;
      quo_q <= {16'd0, div_ge0};
    end else if (cmd_i.div_step) begin
      rem_q <= step_ge ? rem_sub[gcrl_pkg::PosW-1:0] : rem_sh[gcrl_pkg::PosW-1:0];
      quo_q <= {quo_q[gcrl_pkg::QuoW-2:0], step_ge};
    end
  end

  // per-channel scale and rounded blend
  always_comb begin
    logic [gcrl_pkg::ChanW-1:0] a;
    logic [gcrl_pkg::ChanW-1:0] b;
    logic [gcrl_pkg::ChanW-1:0] diff;
    logic [gcrl_pkg::ProdW:0]   rnd;
    logic [gcrl_pkg::ChanW-1:0] delta;
    mix_col = '0;
    for (int k = 0; k < gcrl_pkg::NumCh; k++) begin
      a     = lo_col_q[gcrl_pkg::ColorW-1-gcrl_pkg::ChanW*k -: gcrl_pkg::ChanW];
      b     = hi_col_q[gcrl_pkg::ColorW-1-gcrl_pkg::ChanW*k -: gcrl_pkg::ChanW];
      diff  = (b >= a) ? (b - a) : (a - b);
      prod_d[k] = gcrl_pkg::ProdW'(diff) * gcrl_pkg::ProdW'(quo_q);
      rnd   = {1'b0, prod_q[k]} + (gcrl_pkg::ProdW+1)'(32768);
      delta = rnd[gcrl_pkg::ChanW+15:16];
      mix_col[gcrl_pkg::ColorW-1-gcrl_pkg::ChanW*k -: gcrl_pkg::ChanW] =
        (b >= a) ? (a + delta) : (a - delta);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_load) begin
      for (int k = 0; k < gcrl_pkg::NumCh; k++) begin
        prod_q[k] <= prod_d[k];
      end
    end
  end

  // result and output registers
  always_ff @(posedge clk_i) begin
    case (cmd_i.res_sel)
      gcrl_pkg::RES_RD:   res_q <= rd_col;
      gcrl_pkg::RES_LO:   res_q <= lo_col_q;
      gcrl_pkg::RES_ZERO: res_q <= '0;
      gcrl_pkg::RES_MIX:  res_q <= mix_col;
      default:            res_q <= res_q;
    endcase
    if (cmd_i.out_load) begin
      out_q <= res_q;
    end
  end

  assign out_alpha_o = out_q[63:48];
  assign out_red_o   = out_q[47:32];
  assign out_green_o = out_q[31:16];
  assign out_blue_o  = out_q[15:0];

endmodule

@@ rtl/gcrl_ctrl.sv @@
`timescale 1ns / 1ps

module gcrl_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              op_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output gcrl_pkg::cmd_t    cmd_o,
  input  gcrl_pkg::status_t status_i
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHK_FIRST,
    ST_CHK_LAST,
    ST_SCAN,
    ST_DIV,
    ST_MUL,
    ST_ADD,
    ST_DONE
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   in_acc;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign in_acc      = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;

  // sequencing of the lookup steps
  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q;
    cmd_o       = '0;
    cmd_o.rd_sel  = gcrl_pkg::RD_NONE;
    cmd_o.res_sel = gcrl_pkg::RES_NONE;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (op_i == gcrl_pkg::OP_WRITE) begin
            cmd_o.wr_stop = 1'b1;
          end else begin
            cmd_o.p_load = 1'b1;
            cmd_o.rd_sel = gcrl_pkg::RD_FIRST;
            state_d      = ST_CHK_FIRST;
          end
        end
      end
      ST_CHK_FIRST: begin
        cmd_o.lo_load = 1'b1;
        if (status_i.lt_first) begin
          cmd_o.res_sel = gcrl_pkg::RES_RD;
          state_d       = ST_DONE;
        end else begin
          cmd_o.rd_sel = gcrl_pkg::RD_LAST;
          state_d      = ST_CHK_LAST;
        end
      end
      ST_CHK_LAST: begin
        if (status_i.gt_last) begin
          cmd_o.res_sel = gcrl_pkg::RES_RD;
          state_d       = ST_DONE;
        end else begin
          cmd_o.rd_sel = gcrl_pkg::RD_SEG;
          state_d      = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (status_i.in_seg) begin
          if (status_i.zero_w) begin
            cmd_o.res_sel = gcrl_pkg::RES_LO;
            state_d       = ST_DONE;
          end else begin
            cmd_o.div_start = 1'b1;
            state_d         = ST_DIV;
          end
        end else if (status_i.last_seg) begin
          cmd_o.res_sel = gcrl_pkg::RES_ZERO;
          state_d       = ST_DONE;
        end else begin
          cmd_o.lo_load = 1'b1;
          cmd_o.rd_sel  = gcrl_pkg::RD_NEXT;
        end
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (status_i.div_last) begin
          state_d = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd_o.mul_load = 1'b1;
        state_d        = ST_ADD;
      end
      ST_ADD: begin
        cmd_o.res_sel = gcrl_pkg::RES_MIX;
        state_d       = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // state and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // a write transaction never starts a lookup
  a_write_stays_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && (op_i == gcrl_pkg::OP_WRITE) |=> (state_q == ST_IDLE))
    else $error("write transaction left idle");

  // a new result only appears out of the done step
  a_result_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_DONE))
    else $error("result raised outside done step");

  // the divider runs its full count before the multiply
  a_div_to_mul: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MUL) |-> $past(state_q == ST_DIV) && $past(status_i.div_last))
    else $error("multiply entered before division finished");

  // pending result is not overwritten
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_ready_i && (state_q == ST_DONE) |=> (state_q == ST_DONE))
    else $error("done step left while result still pending");

endmodule

@@ rtl/gradient_color_ramp_lookup_core.sv @@
`timescale 1ns / 1ps

// Gradient color ramp lookup.
// Input channel (in_valid_i / in_ready_o): op_i = 0 writes stop stop_index_i
// with its position and ARGB color, op_i = 1 looks up lookup_position_i.
// Output channel (out_valid_o / out_ready_i): one ARGB color per lookup,
// nothing for a stop write. stop_count_we_i / stop_count_i set the number of
// stops in use; write it only while the block is idle.
// One transaction at a time. A lookup returns the first stop's color when the
// position lies below it and the last stop's color when it lies above it;
// else it scans the segments, returning the lower color of a zero width
// segment that holds the position, zero when no segment holds it, or else a
// blend after a division and a multiply. Its length is set by the single
// table read port that the segment scan walks one stop per cycle and by the
// 17-bit restoring divider for the fraction.
// Results sit in an output register; while the receiver stalls, the next
// transaction is taken and computed, and it waits in its last step until the
// register frees up.
// Reset: stop table reads as black at position 0 and white at position
// 16'hFFFF for stops 0 and 1 (zero elsewhere), stop count 2, no result pending.

module gradient_color_ramp_lookup_core #(
  parameter int unsigned MAX_STOPS = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        stop_count_we_i,
  input  logic [gcrl_pkg::CountW-1:0] stop_count_i,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic                        op_i,
  input  logic [3:0]                  stop_index_i,
  input  logic [gcrl_pkg::PosW-1:0]   stop_position_i,
  input  logic [gcrl_pkg::ChanW-1:0]  stop_alpha_i,
  input  logic [gcrl_pkg::ChanW-1:0]  stop_red_i,
  input  logic [gcrl_pkg::ChanW-1:0]  stop_green_i,
  input  logic [gcrl_pkg::ChanW-1:0]  stop_blue_i,
  input  logic [gcrl_pkg::PosW-1:0]   lookup_position_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [gcrl_pkg::ChanW-1:0]  out_alpha_o,
  output logic [gcrl_pkg::ChanW-1:0]  out_red_o,
  output logic [gcrl_pkg::ChanW-1:0]  out_green_o,
  output logic [gcrl_pkg::ChanW-1:0]  out_blue_o
);

  gcrl_pkg::cmd_t    cmd;
  gcrl_pkg::status_t status;

  // lookup sequencer
  gcrl_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .op_i        (op_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd),
    .status_i    (status)
  );

  // stop table, divider and blend lanes
  gcrl_datapath #(
    .MAX_STOPS (MAX_STOPS)
  ) u_datapath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .status_o          (status),
    .stop_count_we_i   (stop_count_we_i),
    .stop_count_i      (stop_count_i),
    .stop_index_i      (stop_index_i),
    .stop_position_i   (stop_position_i),
    .stop_alpha_i      (stop_alpha_i),
    .stop_red_i        (stop_red_i),
    .stop_green_i      (stop_green_i),
    .stop_blue_i       (stop_blue_i),
    .lookup_position_i (lookup_position_i),
    .out_alpha_o       (out_alpha_o),
    .out_red_o         (out_red_o),
    .out_green_o       (out_green_o),
    .out_blue_o        (out_blue_o)
  );

endmodule

@@ bench/tb_gradient_color_ramp_lookup_core.sv @@
`timescale 1ns / 1ps

module tb_gradient_color_ramp_lookup_core;

  localparam int unsigned NumStops    = 16;
  localparam int unsigned SettleCycles = 45;
  localparam int unsigned StuckLimit  = 2000;
  localparam int unsigned PrintCap    = 40;

  typedef struct packed {
    logic [gcrl_pkg::ChanW-1:0] alpha;
    logic [gcrl_pkg::ChanW-1:0] red;
    logic [gcrl_pkg::ChanW-1:0] green;
    logic [gcrl_pkg::ChanW-1:0] blue;
  } argb_t;

  logic                        clk = 1'b0;
  logic                        rst_n = 1'b0;
  logic                        stop_count_we = 1'b0;
  logic [gcrl_pkg::CountW-1:0] stop_count_val = '0;
  logic                        in_valid = 1'b0;
  logic                        in_ready_o;
  logic                        op = gcrl_pkg::OP_WRITE;
  logic [3:0]                  stop_index = '0;
  logic [gcrl_pkg::PosW-1:0]   stop_position = '0;
  logic [gcrl_pkg::ChanW-1:0]  stop_alpha = '0;
  logic [gcrl_pkg::ChanW-1:0]  stop_red = '0;
  logic [gcrl_pkg::ChanW-1:0]  stop_green = '0;
  logic [gcrl_pkg::ChanW-1:0]  stop_blue = '0;
  logic [gcrl_pkg::PosW-1:0]   lookup_position = '0;
  logic                        out_valid_o;
  logic                        out_ready = 1'b0;
  logic [gcrl_pkg::ChanW-1:0]  out_alpha_o;
  logic [gcrl_pkg::ChanW-1:0]  out_red_o;
  logic [gcrl_pkg::ChanW-1:0]  out_green_o;
  logic [gcrl_pkg::ChanW-1:0]  out_blue_o;

  // own copy of the stop table and the count
  logic [gcrl_pkg::PosW-1:0]   ramp_pos [NumStops];
  argb_t                       ramp_color [NumStops];
  logic [gcrl_pkg::CountW-1:0] ramp_count;

  argb_t pending_colors[$];
  int    error_count = 0;
  bit    idle_on = 1'b1;
  int    stall_left = 0;
  int    stuck_cycles = 0;

  gradient_color_ramp_lookup_core #(
    .MAX_STOPS(NumStops)
  ) DUT (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .stop_count_we_i  (stop_count_we),
    .stop_count_i     (stop_count_val),
    .in_valid_i       (in_valid),
    .in_ready_o       (in_ready_o),
    .op_i             (op),
    .stop_index_i     (stop_index),
    .stop_position_i  (stop_position),
    .stop_alpha_i     (stop_alpha),
    .stop_red_i       (stop_red),
    .stop_green_i     (stop_green),
    .stop_blue_i      (stop_blue),
    .lookup_position_i(lookup_position),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready),
    .out_alpha_o      (out_alpha_o),
    .out_red_o        (out_red_o),
    .out_green_o      (out_green_o),
    .out_blue_o       (out_blue_o)
  );

  always #10 clk = ~clk;

  // power-up table: black at 0, white at full scale
  task automatic ramp_reset();
    for (int i = 0; i < NumStops; i++) begin
      ramp_pos[i]   = '0;
      ramp_color[i] = '0;
    end
    ramp_pos[1]   = 16'hFFFF;
    ramp_color[0] = 64'hFFFF_0000_0000_0000;
    ramp_color[1] = 64'hFFFF_FFFF_FFFF_FFFF;
    ramp_count    = 5'd2;
  endtask

  // one channel moved from a toward b by a 1.16 fraction, rounded
  function automatic logic [gcrl_pkg::ChanW-1:0] blend_chan(
      input logic [gcrl_pkg::ChanW-1:0] a,
      input logic [gcrl_pkg::ChanW-1:0] b,
      input logic [16:0] frac);
    logic [33:0] prod;
    if (b >= a) begin
      prod = (b - a) * frac + 34'd32768;
      return a + prod[31:16];
    end
    prod = (a - b) * frac + 34'd32768;
    return a - prod[31:16];
  endfunction

  function automatic int active_stops();
    if (ramp_count < 2) return 2;
    if (ramp_count > NumStops) return NumStops;
    return int'(ramp_count);
  endfunction

  // color of the ramp at one position
  function automatic argb_t ramp_color_at(input logic [gcrl_pkg::PosW-1:0] p);
    int          n;
    int          i;
    logic [15:0] lo;
    logic [15:0] hi;
    logic [15:0] w;
    logic [31:0] num;
    logic [16:0] frac;
    argb_t       a_c;
    argb_t       b_c;
    argb_t       mixed;
    n = active_stops();
    if (p < ramp_pos[0]) return ramp_color[0];
    if (p > ramp_pos[n-1]) return ramp_color[n-1];
    for (i = 0; i + 1 < n; i++) begin
      lo = ramp_pos[i];
      hi = ramp_pos[i+1];
      if (p >= lo && p <= hi) begin
        w = hi - lo;
        if (w == 0) return ramp_color[i];
        num   = {p - lo, 16'h0000};
        frac  = num / w;
        a_c   = ramp_color[i];
        b_c   = ramp_color[i+1];
        mixed.alpha = blend_chan(a_c.alpha, b_c.alpha, frac);
        mixed.red   = blend_chan(a_c.red, b_c.red, frac);
        mixed.green = blend_chan(a_c.green, b_c.green, frac);
        mixed.blue  = blend_chan(a_c.blue, b_c.blue, frac);
        return mixed;
      end
    end
    return '0;
  endfunction

  task automatic report_mismatch(input string msg);
    if (error_count < PrintCap) $display("mismatch at %0t: %s", $realtime, msg);
    error_count++;
  endtask

  // send one transaction and apply it to the table copy once accepted
  task automatic send_item(input gcrl_pkg::op_e kind, input logic [3:0] idx,
                           input logic [gcrl_pkg::PosW-1:0] spos, input argb_t c,
                           input logic [gcrl_pkg::PosW-1:0] lpos);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid        <= 1'b1;
    op              <= kind;
    stop_index      <= idx;
    stop_position   <= spos;
    stop_alpha      <= c.alpha;
    stop_red        <= c.red;
    stop_green      <= c.green;
    stop_blue       <= c.blue;
    lookup_position <= lpos;
    do @(posedge clk); while (!in_ready_o);
    if (kind == gcrl_pkg::OP_WRITE) begin
      ramp_pos[idx]   = spos;
      ramp_color[idx] = c;
    end else begin
      pending_colors.push_back(ramp_color_at(lpos));
    end
  endtask

  task automatic write_stop(input logic [3:0] idx, input logic [gcrl_pkg::PosW-1:0] pos,
                            input argb_t c);
    send_item(gcrl_pkg::OP_WRITE, idx, pos, c, 16'($urandom));
  endtask

  task automatic lookup_color(input logic [gcrl_pkg::PosW-1:0] pos);
    send_item(gcrl_pkg::OP_LOOKUP, 4'($urandom), 16'($urandom),
              {16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom)}, pos);
  endtask

  // hold the sender until every pending color has come back
  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_colors.size() != 0) @(posedge clk);
  endtask

  // count writes only while idle; a stop write may still be in flight
  task automatic set_stop_count(input logic [gcrl_pkg::CountW-1:0] v);
    drain_results();
    repeat (SettleCycles) @(posedge clk);
    stop_count_we  <= 1'b1;
    stop_count_val <= v;
    @(posedge clk);
    stop_count_we  <= 1'b0;
    ramp_count = v;
  endtask

  function automatic logic [gcrl_pkg::ChanW-1:0] rand_chan();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic argb_t rand_color();
    return {rand_chan(), rand_chan(), rand_chan(), rand_chan()};
  endfunction

  // reset table over the full range
  task automatic test_reset_ramp();
    lookup_color(16'h0000);
    lookup_color(16'h0001);
    lookup_color(16'h8000);
    lookup_color(16'hFFFF);
  endtask

  // below first, zero width, interpolation in both directions, fraction of one, above last
  task automatic test_segment_cases();
    set_stop_count(5'd3);
    write_stop(4'd0, 16'd1000, 64'hFFFF_0000_8000_1234);
    write_stop(4'd1, 16'd1000, 64'h0000_FFFF_0001_FFFF);
    write_stop(4'd2, 16'd60000, 64'hFFFF_0000_7FFF_0000);
    lookup_color(16'd0);
    lookup_color(16'd999);
    lookup_color(16'd1000);
    lookup_color(16'd30500);
    lookup_color(16'd60000);
    lookup_color(16'hFFFF);
  endtask

  // counts outside 2..16 are clamped; last table entry in use
  task automatic test_count_clamp();
    write_stop(4'd15, 16'hFFFF, 64'h5A5A_A5A5_FFFF_0000);
    set_stop_count(5'd31);
    lookup_color(16'hFFFF);
    lookup_color(16'd62000);
    set_stop_count(5'd17);
    lookup_color(16'd61000);
    set_stop_count(5'd1);
    lookup_color(16'd500);
    lookup_color(16'd1000);
    lookup_color(16'd1001);
    set_stop_count(5'd0);
    lookup_color(16'hFFFF);
  endtask

  // sorted ramps with random content, lookups aimed near the stops, some noise writes
  task automatic test_random_ramps();
    logic [gcrl_pkg::CountW-1:0] counts [9];
    int                          n;
    int                          cur;
    int                          step;
    int                          k;
    logic [gcrl_pkg::PosW-1:0]   p;
    counts[0] = 5'd2;
    counts[1] = 5'd16;
    counts[2] = 5'($urandom_range(3, 15));
    counts[3] = 5'd0;
    counts[4] = 5'd31;
    counts[5] = 5'($urandom_range(2, 16));
    counts[6] = 5'd17;
    counts[7] = 5'($urandom_range(2, 16));
    counts[8] = 5'd16;
    for (int ph = 0; ph < 9; ph++) begin
      set_stop_count(counts[ph]);
      idle_on = (ph != 8) && ($urandom_range(0, 3) != 0);
      n   = active_stops();
      cur = ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(0, 8000));
      for (int i = 0; i < n; i++) begin
        write_stop(4'(i), 16'(cur), rand_color());
        step = ($urandom_range(0, 7) == 0) ? 0 : int'($urandom_range(1, 2 * 65535 / (n - 1)));
        cur  = (cur + step > 65535) ? 65535 : cur + step;
      end
      for (int j = 0; j < 36; j++) begin
        if (j == 18) drain_results();
        if ($urandom_range(0, 6) == 0) begin
          write_stop(4'($urandom), 16'($urandom), rand_color());
        end else begin
          k = int'($urandom_range(0, n - 1));
          case ($urandom_range(0, 5))
            0, 1:    p = 16'($urandom);
            2:       p = ramp_pos[k];
            3:       p = ramp_pos[k] + 16'd1;
            4:       p = ramp_pos[k] - 16'd1;
            default: p = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
          endcase
          lookup_color(p);
        end
      end
    end
  endtask

  // receiver stalls in short bursts
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready  <= 1'b0;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      stall_left <= int'($urandom_range(0, 3));
      out_ready  <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // compare each result transaction with the oldest pending color
  always @(posedge clk) begin : color_check
    argb_t want;
    if (rst_n && out_valid_o && out_ready) begin
      if (pending_colors.size() == 0) begin
        report_mismatch($sformatf("result %h_%h_%h_%h with no lookup pending",
                                  out_alpha_o, out_red_o, out_green_o, out_blue_o));
      end else begin
        want = pending_colors.pop_front();
        if (out_alpha_o !== want.alpha)
          report_mismatch($sformatf("alpha %h, expected %h", out_alpha_o, want.alpha));
        if (out_red_o !== want.red)
          report_mismatch($sformatf("red %h, expected %h", out_red_o, want.red));
        if (out_green_o !== want.green)
          report_mismatch($sformatf("green %h, expected %h", out_green_o, want.green));
        if (out_blue_o !== want.blue)
          report_mismatch($sformatf("blue %h, expected %h", out_blue_o, want.blue));
      end
    end
  end

  // watchdog on cycles with no transaction on either side
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready_o) || (out_valid_o && out_ready)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= StuckLimit) begin
      $display("tb: failure");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  initial begin
    ramp_reset();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_ramp();
    test_segment_cases();
    test_count_clamp();
    test_random_ramps();
    drain_results();
    repeat (SettleCycles) @(posedge clk);
    if (error_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

@@ gradient_color_ramp_lookup_core.f @@
rtl/gcrl_pkg.sv
rtl/gcrl_datapath.sv
rtl/gcrl_ctrl.sv
rtl/gradient_color_ramp_lookup_core.sv
bench/tb_gradient_color_ramp_lookup_core.sv
